// ===== src/sci_pkg.sv =====
// shared types, constants and decode helpers for the serial command interpreter
`timescale 1ns / 1ps

package sci_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int PREFIX_LEN   = 6;
    localparam int PREFIX_IDX_W = $clog2(PREFIX_LEN);

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int STALL_W      = 14;
    localparam int RANGE_W      = 13;
    localparam int CFG_W        = 14;
    localparam int CFG_IDX_W    = 2;
    localparam int WIDTH_W      = 16;
    localparam int MAG_W        = 7;
    localparam int PROD_W       = RANGE_W + MAG_W;
    localparam int QIN_W        = PROD_W - 2;
    localparam int RECIP_W      = 19;
    localparam int DIV_SHIFT    = 23;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 19'd335545;
    localparam logic [MAG_W-1:0]   MAG_MAX   = 7'd100;

    localparam int OUT_TDATA_W  = 48;
    localparam int OUT_USED_W   = 2 * WIDTH_W + 3 + 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_USED_W;
    localparam int OUT_TUSER_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_STALL_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_RANGE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR_CHAR = 2'd2;

    localparam logic [STALL_W-1:0] STALL_RESET = 14'd750;
    localparam logic [RANGE_W-1:0] RANGE_RESET = 13'd250;
    localparam logic [7:0]         TERM_RESET  = 8'd59;
    localparam logic [WIDTH_W-1:0] SERVO_RESET = 16'd750;
    localparam logic [7:0]         LED_RESET   = 8'd36;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN_CMD = 2'd1;
    localparam logic [1:0] ERR_BAD_IR      = 2'd2;
    localparam logic [1:0] ERR_BAD_LED     = 2'd3;

    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [7:0] DIGIT_SEGS [10] = '{
        8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'h78, 8'h00, 8'h10
    };
    localparam logic [7:0] LETTER_SEGS [26] = '{
        8'h08, 8'h03, 8'h46, 8'h21, 8'h06, 8'h0E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h36, 8'h4F, 8'h79, 8'h5B, 8'h6D, 8'h27, 8'h23, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1C
    };

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MOTOR_A,
        OP_MOTOR_B,
        OP_IR_SET,
        OP_IR_CLR,
        OP_LED
    } op_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [1:0]       err;
        op_t              op;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [2:0]       mask;
        logic [7:0]       segs;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            r = c - CASE_OFS;
        end
        return r;
    endfunction

    function automatic logic [7:0] led_pattern(input logic [7:0] ch, input logic [7:0] dec);
        logic [7:0] u;
        logic [7:0] segs;
        u    = upcase(ch);
        segs = 8'h00;
        if (u >= CH_0 && u <= CH_9) begin
            segs = DIGIT_SEGS[4'(u - CH_0)];
        end else if (u >= CH_A && u <= CH_Z) begin
            segs = LETTER_SEGS[5'(u - CH_A)];
        end
        if (upcase(dec) != CH_D) begin
            segs[7] = 1'b1;
        end
        return segs;
    endfunction

endpackage

// ===== src/sci_front.sv =====
// front end: collects message bytes and classifies the command on the terminator
`timescale 1ns / 1ps

module sci_front
    import sci_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] terminator_char,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  q_status_t  q_stat,
    output logic       push,
    output cmd_t       push_data
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [7:0]       pref_reg [PREFIX_LEN];
    logic [7:0]       m [PREFIX_LEN];
    logic             store;
    logic             is_term;
    logic [7:0]       cmd_ch;
    logic [7:0]       sub_ch;
    logic [10:0]      mag_raw;
    logic [MAG_W-1:0] mag;

    function automatic logic [2:0] ir_mask(input logic [7:0] unit);
        logic [2:0] r;
        case (unit)
            8'd1:    r = 3'b001;
            8'd2:    r = 3'b010;
            8'd3:    r = 3'b100;
            default: r = 3'b111;
        endcase
        return r;
    endfunction

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;
    assign store    = cnt_reg < CNT_W'(BUFFER_DEPTH);
    assign is_term  = s_tdata == terminator_char;

    // message view as decoding sees it, including the byte arriving now
    always_comb begin
        for (int i = 0; i < PREFIX_LEN; i++) begin
            if (CNT_W'(i) < cnt_reg) begin
                m[i] = pref_reg[i];
            end else if (CNT_W'(i) == cnt_reg && store) begin
                m[i] = s_tdata;
            end else begin
                m[i] = 8'h00;
            end
        end
    end

    assign cmd_ch  = upcase(m[0]);
    assign sub_ch  = upcase(m[1]);
    assign mag_raw = 11'(m[3][3:0]) * 11'd100 + 11'(m[4][3:0]) * 11'd10 + 11'(m[5][3:0]);
    assign mag     = (mag_raw > 11'(MAG_MAX)) ? MAG_MAX : mag_raw[MAG_W-1:0];

    always_comb begin
        push_data      = '0;
        push_data.op   = OP_NONE;
        push_data.ovf  = !store;
        push_data.done = is_term;
        if (is_term) begin
            if (cmd_ch == CH_M) begin
                push_data.mag = mag;
                push_data.neg = (m[2] == CH_MINUS) && (mag != '0);
                if (sub_ch == CH_A) begin
                    push_data.op = OP_MOTOR_A;
                end else if (sub_ch == CH_B) begin
                    push_data.op = OP_MOTOR_B;
                end
            end else if (cmd_ch == CH_I) begin
                push_data.mask = ir_mask(m[2]);
                if (sub_ch == CH_I) begin
                    push_data.op = OP_IR_SET;
                end else if (sub_ch == CH_O) begin
                    push_data.op = OP_IR_CLR;
                end else begin
                    push_data.err = ERR_BAD_IR;
                end
            end else if (cmd_ch == CH_L) begin
                if (m[2] == terminator_char) begin
                    push_data.err = ERR_BAD_LED;
                end else begin
                    push_data.op   = OP_LED;
                    push_data.segs = led_pattern(m[1], m[2]);
                end
            end else begin
                push_data.err = ERR_UNKNOWN_CMD;
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (is_term) begin
            cnt_next = '0;
        end else if (store) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (push) begin
            cnt_reg <= cnt_next;
        end
    end

    // only the leading bytes take part in decoding
    always_ff @(posedge aclk) begin
        if (push && cnt_reg < CNT_W'(PREFIX_LEN)) begin
            pref_reg[cnt_reg[PREFIX_IDX_W-1:0]] <= s_tdata;
        end
    end

endmodule

// ===== src/sci_queue.sv =====
// small command queue between the front end and the execution back end
`timescale 1ns / 1ps

module sci_queue
    import sci_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_data,
    input  logic      pop,
    output cmd_t      pop_data,
    output q_status_t q_stat
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign q_stat.full  = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_stat.empty = cnt_reg == '0;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/sci_back.sv =====
// back end: motor arithmetic, output state update and result register
`timescale 1ns / 1ps

module sci_back
    import sci_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [STALL_W-1:0]     stall_width,
    input  logic [RANGE_W-1:0]     motor_range,
    input  q_status_t              q_stat,
    input  cmd_t                   pop_data,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic [OUT_TUSER_W-1:0] m_tuser
);

    logic                         adv;
    logic                         v1_reg;
    logic                         v2_reg;
    logic                         out_valid_reg;
    cmd_t                         rec1_reg;
    cmd_t                         rec2_reg;
    logic [PROD_W-1:0]            prod1_reg;
    logic [RANGE_W-1:0]           quot2_reg;
    logic [QIN_W+RECIP_W-1:0]     recip_prod;
    logic [WIDTH_W-1:0]           servo_a_reg;
    logic [WIDTH_W-1:0]           servo_b_reg;
    logic [2:0]                   ir_reg;
    logic [7:0]                   led_reg;
    logic [WIDTH_W-1:0]           servo_a_next;
    logic [WIDTH_W-1:0]           servo_b_next;
    logic [2:0]                   ir_next;
    logic [7:0]                   led_next;
    logic                         done_reg;
    logic [1:0]                   err_reg;
    logic                         ovf_reg;
    logic [WIDTH_W-1:0]           width_plus;
    logic [WIDTH_W-1:0]           width_minus;

    assign adv = !out_valid_reg || m_tready;
    assign pop = adv && !q_stat.empty;

    // divide by 100 as a divide by 4 then a reciprocal multiply for 25
    assign recip_prod = (QIN_W + RECIP_W)'(prod1_reg[PROD_W-1:2])
                      * (QIN_W + RECIP_W)'(DIV_RECIP);

    assign width_plus  = WIDTH_W'(stall_width) + WIDTH_W'(quot2_reg);
    assign width_minus = (STALL_W'(quot2_reg) >= stall_width) ? '0
                       : WIDTH_W'(stall_width - STALL_W'(quot2_reg));

    always_comb begin
        servo_a_next = servo_a_reg;
        servo_b_next = servo_b_reg;
        ir_next      = ir_reg;
        led_next     = led_reg;
        case (rec2_reg.op)
            OP_MOTOR_A: servo_a_next = rec2_reg.neg ? width_plus : width_minus;
            OP_MOTOR_B: servo_b_next = rec2_reg.neg ? width_minus : width_plus;
            OP_IR_SET:  ir_next      = ir_reg | rec2_reg.mask;
            OP_IR_CLR:  ir_next      = ir_reg & ~rec2_reg.mask;
            OP_LED:     led_next     = rec2_reg.segs;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            servo_a_reg   <= SERVO_RESET;
            servo_b_reg   <= SERVO_RESET;
            ir_reg        <= '0;
            led_reg       <= LED_RESET;
        end else if (adv) begin
            v1_reg        <= !q_stat.empty;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
            if (v2_reg) begin
                servo_a_reg <= servo_a_next;
                servo_b_reg <= servo_b_next;
                ir_reg      <= ir_next;
                led_reg     <= led_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rec1_reg  <= pop_data;
            prod1_reg <= PROD_W'(motor_range) * PROD_W'(pop_data.mag);
            rec2_reg  <= rec1_reg;
            quot2_reg <= recip_prod[DIV_SHIFT +: RANGE_W];
            done_reg  <= rec2_reg.done;
            err_reg   <= rec2_reg.err;
            ovf_reg   <= rec2_reg.ovf;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {OUT_PAD_W'(0), led_reg, ir_reg, servo_b_reg, servo_a_reg};
    assign m_tlast  = done_reg;
    assign m_tuser  = {ovf_reg, err_reg};

endmodule

// ===== src/serial_command_interpreter_unit.sv =====
// top level of the serial command interpreter
//
//  port group   dir  fields (lsb first)
//  s_t*         in   tdata: rx_byte
//  m_t*         out  tdata: servo_a_width, servo_b_width, ir_enables, led_segments
//                    tlast: message_done   tuser: error_code, overflow
//  cfg_*        in   index 0 stall_width, 1 motor_range, 2 terminator_char
//
//  one request in and one result out per cycle when both sides keep up
//  each accepted request is queued, then registered through multiply, reciprocal and update before its result is valid
//  a four-entry command queue takes up to four more requests while m_tready is low
//  synchronous active-low reset, no clearing pass; the queue is empty and ready after reset
`timescale 1ns / 1ps

module serial_command_interpreter_unit
    import sci_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // servo_a, servo_b, ir_enables, led_segments
    output logic                   m_tlast,
    output logic [OUT_TUSER_W-1:0] m_tuser,   // error_code, overflow
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    logic [STALL_W-1:0] stall_width_reg;
    logic [RANGE_W-1:0] motor_range_reg;
    logic [7:0]         terminator_char_reg;
    q_status_t          q_stat;
    logic               push;
    logic               pop;
    cmd_t               push_data;
    cmd_t               pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_width_reg     <= STALL_RESET;
            motor_range_reg     <= RANGE_RESET;
            terminator_char_reg <= TERM_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_STALL_WIDTH:     stall_width_reg     <= cfg_wdata[STALL_W-1:0];
                REG_MOTOR_RANGE:     motor_range_reg     <= cfg_wdata[RANGE_W-1:0];
                REG_TERMINATOR_CHAR: terminator_char_reg <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    sci_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .terminator_char (terminator_char_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .q_stat          (q_stat),
        .push            (push),
        .push_data       (push_data)
    );

    sci_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    sci_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stall_width (stall_width_reg),
        .motor_range (motor_range_reg),
        .q_stat      (q_stat),
        .pop_data    (pop_data),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== src/sci_checker.sv =====
// port-level checks for the serial command interpreter, bound to the top level
`timescale 1ns / 1ps

module sci_checker
    import sci_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast,
    input logic [OUT_TUSER_W-1:0] m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // an error code only comes with a decoded message
    a_err_needs_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] != ERR_NONE) |-> m_tlast)
        else $error("error code without message end");

    // after reset the queue is empty and nothing is pending
    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("state left over after reset");

endmodule

bind serial_command_interpreter_unit sci_checker u_sci_checker (.*);

// ===== verif/serial_command_interpreter_unit_tb.sv =====
// self-checking testbench for the serial command interpreter: directed table, then random messages
`timescale 1ns / 1ps

module serial_command_interpreter_unit_tb;
    import sci_pkg::*;

    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_X    = 8'h58;
    localparam int         PHASES  = 6;
    localparam int         PHASE_ITEMS = 300;

    localparam logic [7:0] DIGIT_TAB [10] = '{
        8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'h78, 8'h00, 8'h10
    };
    localparam logic [7:0] LETTER_TAB [26] = '{
        8'h08, 8'h03, 8'h46, 8'h21, 8'h06, 8'h0E, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h36, 8'h4F, 8'h79, 8'h5B, 8'h6D, 8'h27, 8'h23, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1C
    };

    typedef struct packed {
        logic [15:0] servo_a;
        logic [15:0] servo_b;
        logic [2:0]  ir;
        logic [7:0]  segs;
        logic        done;
        logic [1:0]  err;
        logic        ovf;
    } reply_t;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        reply_t     want;
    } drow_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;

    // interpreter state as the testbench sees it
    logic [7:0]   msg_mem [BUFFER_DEPTH];
    int           msg_len;
    logic [15:0]  pw_a;
    logic [15:0]  pw_b;
    logic [2:0]   ir_bits;
    logic [7:0]   seg_reg;
    logic [13:0]  cfg_stall;
    logic [12:0]  cfg_range;
    logic [7:0]   cfg_term;

    reply_t       want_replies [$];
    drow_t        dir_tab [$];
    logic [7:0]   msg_q [$];
    int           err_cnt = 0;
    int           n_sent = 0;
    bit           burst = 1'b0;

    serial_command_interpreter_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [7:0] msg_at(input int pos);
        if (pos < msg_len && pos < BUFFER_DEPTH) begin
            return msg_mem[pos];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            return c - CASE_OFS;
        end
        return c;
    endfunction

    function automatic logic [15:0] pw_plus(input int delta);
        return 16'(int'(cfg_stall) + delta);
    endfunction

    function automatic logic [15:0] pw_minus(input int delta);
        if (delta >= int'(cfg_stall)) begin
            return 16'd0;
        end
        return 16'(int'(cfg_stall) - delta);
    endfunction

    function automatic logic [2:0] unit_mask(input logic [7:0] unit);
        case (unit)
            8'd1:    return 3'b001;
            8'd2:    return 3'b010;
            8'd3:    return 3'b100;
            default: return 3'b111;
        endcase
    endfunction

    function automatic logic [1:0] run_command();
        logic [7:0] cmd;
        logic [7:0] sub;
        logic [7:0] ch;
        logic [7:0] segs;
        bit         neg;
        int         mag;
        int         delta;
        cmd = to_upper(msg_at(0));
        if (cmd == CH_M) begin
            sub = to_upper(msg_at(1));
            neg = (msg_at(2) == CH_MINUS);
            mag = int'(msg_at(3) & 8'h0F) * 100 + int'(msg_at(4) & 8'h0F) * 10
                + int'(msg_at(5) & 8'h0F);
            if (mag > 100) begin
                mag = 100;
            end
            delta = (int'(cfg_range) * mag) / 100;
            if (mag == 0) begin
                neg = 1'b0;
            end
            if (sub == CH_A) begin
                pw_a = neg ? pw_plus(delta) : pw_minus(delta);
            end else if (sub == CH_B) begin
                pw_b = neg ? pw_minus(delta) : pw_plus(delta);
            end
            return ERR_NONE;
        end
        if (cmd == CH_I) begin
            sub = to_upper(msg_at(1));
            if (sub == CH_I) begin
                ir_bits = ir_bits | unit_mask(msg_at(2));
            end else if (sub == CH_O) begin
                ir_bits = ir_bits & ~unit_mask(msg_at(2));
            end else begin
                return ERR_BAD_IR;
            end
            return ERR_NONE;
        end
        if (cmd == CH_L) begin
            if (msg_at(2) == cfg_term) begin
                return ERR_BAD_LED;
            end
            ch   = to_upper(msg_at(1));
            segs = 8'h00;
            if (ch >= CH_0 && ch <= CH_9) begin
                segs = DIGIT_TAB[ch - CH_0];
            end else if (ch >= CH_A && ch <= CH_Z) begin
                segs = LETTER_TAB[ch - CH_A];
            end
            if (to_upper(msg_at(2)) != CH_D) begin
                segs[7] = 1'b1;
            end
            seg_reg = segs;
            return ERR_NONE;
        end
        return ERR_UNKNOWN_CMD;
    endfunction

    function automatic reply_t interpret_byte(input logic [7:0] b);
        reply_t r;
        r      = '0;
        if (msg_len < BUFFER_DEPTH) begin
            msg_mem[msg_len] = b;
            msg_len++;
        end else begin
            r.ovf = 1'b1;
        end
        if (b == cfg_term) begin
            r.done  = 1'b1;
            r.err   = run_command();
            msg_len = 0;
        end
        r.servo_a = pw_a;
        r.servo_b = pw_b;
        r.ir      = ir_bits;
        r.segs    = seg_reg;
        return r;
    endfunction

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_cnt++;
        if (err_cnt <= 40) begin
            $display("mismatch %s: got %0h expected %0h", what, got, want);
        end
    endtask

    task automatic add_row(input logic [7:0] b, input bit typed = 1'b0,
                           input reply_t want = '0);
        drow_t row;
        row.b     = b;
        row.typed = typed;
        row.want  = want;
        dir_tab.push_back(row);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input reply_t want = '0);
        int     gap;
        reply_t pred;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        pred = interpret_byte(b);
        want_replies.push_back(typed ? want : pred);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (want_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
        case (idx)
            REG_STALL_WIDTH:     cfg_stall = val[13:0];
            REG_MOTOR_RANGE:     cfg_range = val[12:0];
            REG_TERMINATOR_CHAR: cfg_term  = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int stall, input int range_val, input int term);
        drain();
        write_reg(REG_STALL_WIDTH, stall);
        write_reg(REG_MOTOR_RANGE, range_val);
        write_reg(REG_TERMINATOR_CHAR, term);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic build_message();
        int         kind;
        int         mode;
        int         len;
        bit         add_term;
        logic [7:0] b;
        msg_q.delete();
        kind     = $urandom_range(0, 15);
        add_term = ($urandom_range(0, 15) != 0);
        if (kind < 5) begin
            // motor request
            msg_q.push_back(coin() ? CH_M : CH_M + CASE_OFS);
            case ($urandom_range(0, 4))
                0:       b = CH_A;
                1:       b = CH_A + CASE_OFS;
                2:       b = CH_B;
                3:       b = CH_B + CASE_OFS;
                default: b = rand_byte();
            endcase
            msg_q.push_back(b);
            case ($urandom_range(0, 4))
                0, 1:    b = CH_MINUS;
                2, 3:    b = CH_PLUS;
                default: b = rand_byte();
            endcase
            msg_q.push_back(b);
            mode = $urandom_range(0, 5);
            for (int i = 0; i < 3; i++) begin
                if (mode == 0 || (mode == 1 && i == 0)) begin
                    b = CH_0;
                end else if ($urandom_range(0, 7) == 0) begin
                    b = rand_byte();
                end else begin
                    b = CH_0 + 8'($urandom_range(0, 9));
                end
                msg_q.push_back(b);
            end
        end else if (kind < 9) begin
            // ir request
            msg_q.push_back(coin() ? CH_I : CH_I + CASE_OFS);
            case ($urandom_range(0, 4))
                0:       b = CH_I;
                1:       b = CH_I + CASE_OFS;
                2:       b = CH_O;
                3:       b = CH_O + CASE_OFS;
                default: b = rand_byte();
            endcase
            msg_q.push_back(b);
            mode = $urandom_range(0, 4);
            msg_q.push_back(mode < 4 ? 8'(mode) : rand_byte());
        end else if (kind < 12) begin
            // led request
            msg_q.push_back(coin() ? CH_L : CH_L + CASE_OFS);
            case ($urandom_range(0, 3))
                0:       b = CH_0 + 8'($urandom_range(0, 9));
                1:       b = CH_A + 8'($urandom_range(0, 25));
                2:       b = CH_LOW_A + 8'($urandom_range(0, 25));
                default: b = rand_byte();
            endcase
            msg_q.push_back(b);
            case ($urandom_range(0, 3))
                0:       b = CH_D;
                1:       b = CH_D + CASE_OFS;
                2:       b = cfg_term;
                default: b = rand_byte();
            endcase
            msg_q.push_back(b);
        end else begin
            // noise, long runs overflow the buffer
            len = $urandom_range(0, 45);
            repeat (len) msg_q.push_back(rand_byte());
            add_term = coin();
        end
        if (kind < 12 && $urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, msg_q.size() - 1);
            repeat (len) void'(msg_q.pop_back());
        end
        if (add_term) begin
            msg_q.push_back(cfg_term);
        end
    endtask

    task automatic check_reply();
        reply_t want;
        if (want_replies.size() == 0) begin
            report_mismatch("unexpected result", longint'(m_tdata), 0);
            return;
        end
        want = want_replies.pop_front();
        if (m_tdata[15:0] !== want.servo_a) begin
            report_mismatch("servo_a_width", m_tdata[15:0], want.servo_a);
        end
        if (m_tdata[31:16] !== want.servo_b) begin
            report_mismatch("servo_b_width", m_tdata[31:16], want.servo_b);
        end
        if (m_tdata[34:32] !== want.ir) begin
            report_mismatch("ir_enables", m_tdata[34:32], want.ir);
        end
        if (m_tdata[42:35] !== want.segs) begin
            report_mismatch("led_segments", m_tdata[42:35], want.segs);
        end
        if (m_tdata[OUT_TDATA_W-1:OUT_USED_W] !== '0) begin
            report_mismatch("tdata padding", m_tdata[OUT_TDATA_W-1:OUT_USED_W], 0);
        end
        if (m_tlast !== want.done) begin
            report_mismatch("message_done", m_tlast, want.done);
        end
        if (m_tuser[1:0] !== want.err) begin
            report_mismatch("error_code", m_tuser[1:0], want.err);
        end
        if (m_tuser[2] !== want.ovf) begin
            report_mismatch("overflow", m_tuser[2], want.ovf);
        end
    endtask

    // result side
    initial begin
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            check_reply();
        end
    end

    // request side and run control
    initial begin
        int target;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        foreach (msg_mem[i]) msg_mem[i] = 8'h00;
        msg_len   = 0;
        pw_a      = SERVO_RESET;
        pw_b      = SERVO_RESET;
        ir_bits   = 3'd0;
        seg_reg   = LED_RESET;
        cfg_stall = STALL_RESET;
        cfg_range = RANGE_RESET;
        cfg_term  = TERM_RESET;

        // short message of an unknown command, then motor extremes, ir and led errors, an ir set and a valid led
        add_row(8'hFF, 1'b1, reply_t'{16'd750, 16'd750, 3'd0, 8'd36, 1'b0, ERR_NONE, 1'b0});
        add_row(CH_SEMI, 1'b1,
                reply_t'{16'd750, 16'd750, 3'd0, 8'd36, 1'b1, ERR_UNKNOWN_CMD, 1'b0});
        add_row(CH_M);
        add_row(CH_A);
        add_row(CH_PLUS);
        add_row(CH_0 + 8'd1);
        add_row(CH_0);
        add_row(CH_0);
        add_row(CH_SEMI, 1'b1,
                reply_t'{16'd500, 16'd750, 3'd0, 8'd36, 1'b1, ERR_NONE, 1'b0});
        add_row(CH_M + CASE_OFS);
        add_row(CH_B + CASE_OFS);
        add_row(CH_MINUS);
        add_row(CH_9);
        add_row(CH_9);
        add_row(CH_9);
        add_row(CH_SEMI, 1'b1,
                reply_t'{16'd500, 16'd500, 3'd0, 8'd36, 1'b1, ERR_NONE, 1'b0});
        add_row(CH_I);
        add_row(CH_X);
        add_row(8'd1);
        add_row(CH_SEMI, 1'b1,
                reply_t'{16'd500, 16'd500, 3'd0, 8'd36, 1'b1, ERR_BAD_IR, 1'b0});
        add_row(CH_I + CASE_OFS);
        add_row(CH_I + CASE_OFS);
        add_row(8'd2);
        add_row(CH_SEMI);
        add_row(CH_L);
        add_row(CH_A);
        add_row(CH_SEMI, 1'b1,
                reply_t'{16'd500, 16'd500, 3'd2, 8'd36, 1'b1, ERR_BAD_LED, 1'b0});
        add_row(CH_L + CASE_OFS);
        add_row(CH_0 + 8'd8);
        add_row(CH_D + CASE_OFS);
        add_row(CH_SEMI);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(0, 5000, CH_SEMI);
                1: set_config(10000, 5000, CH_SEMI);
                2: set_config(10000, 0, 8'h0D);
                3: set_config(0, 0, 8'hFF);
                4: set_config($urandom_range(0, 10000), $urandom_range(0, 5000), 8'h00);
                default: set_config($urandom_range(0, 10000), $urandom_range(0, 5000),
                                    $urandom_range(0, 255));
            endcase
            target = n_sent + PHASE_ITEMS;
            while (n_sent < target) begin
                burst = ($urandom_range(0, 5) == 0);
                build_message();
                foreach (msg_q[i]) send_byte(msg_q[i]);
            end
        end

        drain();
        burst = 1'b0;
        while (want_replies.size() != 0) begin
            report_mismatch("missing result", 0, longint'(want_replies.pop_front()));
        end
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== serial_command_interpreter_unit.f =====
src/sci_pkg.sv
src/sci_front.sv
src/sci_queue.sv
src/sci_back.sv
src/serial_command_interpreter_unit.sv
src/sci_checker.sv
verif/serial_command_interpreter_unit_tb.sv
